// ----- hw/rtl/atrp_pkg.sv -----
`timescale 1ns / 1ps

package atrp_pkg;

    // field widths
    localparam int IN_W        = 16;
    localparam int OUT_W       = 17;
    localparam int SQ_W        = 32;
    // cordic operand width, holds magnitudes up to 2^45 with sign
    localparam int OP_W        = 48;
    // cordic working width, growth of about 1.65 over the operands
    localparam int CW          = 50;
    // angle accumulator, degrees * 2^32
    localparam int Z_W         = 41;
    localparam int PHI_W       = 42;
    localparam int ANG_W       = 40;
    // root remainder and partial result width
    localparam int RW          = 64;

    localparam int CORDIC_STEPS = 32;
    localparam int ROOT_STEPS   = 31;
    // operands are scaled up until one of them reaches 2^44
    localparam int NORM_LEN     = 45;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam real DEG_PER_RAD = 57.295779513082320876798154814105;

    // one classified sample on its way to the back end
    typedef struct packed {
        logic                rp;
        logic signed [16:0]  dir_a;
        logic signed [15:0]  dir_b;
        logic signed [16:0]  num;
        logic [SQ_W-1:0]     sq_a;
        logic [SQ_W-1:0]     sq_b;
    } atrp_item_t;

    // queue status seen by the front and the top
    typedef struct packed {
        logic full;
        logic empty;
    } atrp_qstat_t;

    // atan(2^-step) in degrees * 2^32, evaluated at elaboration
    function automatic logic [ANG_W-1:0] cordic_angle(input int step);
        real t;
        real a;
        logic [ANG_W-1:0] res;
        t = 2.0 ** (-step);
        a = 0.0;
        res = '0;
        case (step)
            0: a = 0.785398163397448309616;
            1: a = 0.463647609000806116214;
            2: a = 0.244978663126864154172;
            3: a = 0.124354994546761435031;
            default: a = t - (t ** 3) / 3.0 + (t ** 5) / 5.0 - (t ** 7) / 7.0
                         + (t ** 9) / 9.0;
        endcase
        if (step == 0)
            res = ANG_W'(45) << 32;
        else
            res = a * DEG_PER_RAD * 4294967296.0;
        return res;
    endfunction

endpackage

// ----- hw/rtl/atrp_front.sv -----
`timescale 1ns / 1ps

module atrp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [15:0]            accel_x,
    input  logic signed [15:0]            accel_y,
    input  logic signed [15:0]            accel_z,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  atrp_pkg::atrp_qstat_t         qstat,
    output logic                          push,
    output atrp_pkg::atrp_item_t          item
);

    logic               lim_pitch_reg;
    logic               lim_pitch_next;
    logic signed [15:0] den_m;
    logic signed [31:0] prod_a;
    logic signed [31:0] prod_b;
    logic signed [16:0] neg_x;
    logic signed [16:0] ext_y;

    // mode register, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        lim_pitch_next = lim_pitch_reg;
        if (cfg_valid)
            lim_pitch_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lim_pitch_reg <= 1'b1;
        else
            lim_pitch_reg <= lim_pitch_next;
    end

    // accept when the queue has room
    assign push = start && !qstat.full;

    // pick operands for the direct atan2 and the atan over root
    always_comb
    begin
        neg_x  = 17'sd0 - $signed({accel_x[15], accel_x});
        ext_y  = $signed({accel_y[15], accel_y});
        den_m  = lim_pitch_reg ? accel_y : accel_x;
        prod_a = den_m * den_m;
        prod_b = accel_z * accel_z;

        item.rp    = lim_pitch_reg;
        item.dir_a = lim_pitch_reg ? ext_y : neg_x;
        item.dir_b = accel_z;
        item.num   = lim_pitch_reg ? neg_x : ext_y;
        item.sq_a  = unsigned'(prod_a);
        item.sq_b  = unsigned'(prod_b);
    end

endmodule

// ----- hw/rtl/atrp_queue.sv -----
`timescale 1ns / 1ps

module atrp_queue
#(
    parameter int DEPTH = atrp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  atrp_pkg::atrp_item_t  push_item,
    input  logic                  pop,
    output atrp_pkg::atrp_item_t  head,
    output atrp_pkg::atrp_qstat_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    atrp_pkg::atrp_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/atrp_root.sv -----
`timescale 1ns / 1ps

module atrp_root
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  atrp_pkg::atrp_item_t                 in_item,
    output logic                                 out_valid,
    output logic signed [atrp_pkg::OP_W-1:0]     roll_a,
    output logic signed [atrp_pkg::OP_W-1:0]     roll_b,
    output logic signed [atrp_pkg::OP_W-1:0]     pitch_a,
    output logic signed [atrp_pkg::OP_W-1:0]     pitch_b
);

    localparam int NS = atrp_pkg::ROOT_STEPS + 1;
    localparam int RW = atrp_pkg::RW;
    localparam int OP_W = atrp_pkg::OP_W;

    // sum of squares stage
    logic                      v0_reg;
    logic [atrp_pkg::SQ_W-1:0] s0_reg;
    atrp_pkg::atrp_item_t      it0_reg;

    // shift count stage
    logic                      v1_reg;
    logic [atrp_pkg::SQ_W-1:0] s1_reg;
    logic [4:0]                m1_reg;
    atrp_pkg::atrp_item_t      it1_reg;
    logic [5:0]                blen;
    logic [4:0]                m_calc;

    // root pipeline, index 0 holds the normalized radicand
    logic                      vq_reg  [NS];
    logic [RW-1:0]             rem_reg [NS];
    logic [RW-1:0]             res_reg [NS];
    logic [4:0]                m_reg   [NS];
    logic                      rp_reg  [NS];
    logic signed [16:0]        da_reg  [NS];
    logic signed [15:0]        db_reg  [NS];
    logic signed [16:0]        num_reg [NS];

    logic signed [OP_W-1:0]    num_sc;
    logic signed [OP_W-1:0]    root_b;
    logic signed [OP_W-1:0]    dir_a;
    logic signed [OP_W-1:0]    dir_b;

    // bit length of the sum, then shift to at least 2^60
    always_comb
    begin
        blen = '0;
        for (int b = 0; b < atrp_pkg::SQ_W; b++)
        begin
            if (s0_reg[b])
                blen = 6'(b + 1);
        end
        m_calc = (blen == '0) ? 5'd0 : 5'((6'd62 - blen) >> 1);
    end

    always_ff @(posedge clk)
    begin
        s0_reg     <= in_item.sq_a + in_item.sq_b;
        it0_reg    <= in_item;
        s1_reg     <= s0_reg;
        m1_reg     <= m_calc;
        it1_reg    <= it0_reg;
        rem_reg[0] <= RW'(s1_reg) << {m1_reg, 1'b0};
        res_reg[0] <= '0;
        m_reg[0]   <= m1_reg;
        rp_reg[0]  <= it1_reg.rp;
        da_reg[0]  <= it1_reg.dir_a;
        db_reg[0]  <= it1_reg.dir_b;
        num_reg[0] <= it1_reg.num;
    end

    // one result bit per stage
    for (genvar j = 0; j < atrp_pkg::ROOT_STEPS; j++)
    begin : g_root
        localparam logic [RW-1:0] BITV = RW'(1) << (60 - 2 * j);
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_n;
        logic [RW-1:0] res_n;

        always_comb
        begin
            trial = res_reg[j] + BITV;
            if (rem_reg[j] >= trial)
            begin
                rem_n = rem_reg[j] - trial;
                res_n = (res_reg[j] >> 1) + BITV;
            end
            else
            begin
                rem_n = rem_reg[j];
                res_n = res_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= rem_n;
            res_reg[j+1] <= res_n;
            m_reg[j+1]   <= m_reg[j];
            rp_reg[j+1]  <= rp_reg[j];
            da_reg[j+1]  <= da_reg[j];
            db_reg[j+1]  <= db_reg[j];
            num_reg[j+1] <= num_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vq_reg[j+1] <= 1'b0;
            else
                vq_reg[j+1] <= vq_reg[j];
        end
    end

    // valid chain at the front of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            vq_reg[0] <= 1'b0;
        end
        else
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            vq_reg[0] <= v1_reg;
        end
    end

    // scale numerator like the root of the radicand and steer to roll and pitch
    always_comb
    begin
        num_sc = OP_W'(num_reg[NS-1]) <<< m_reg[NS-1];
        root_b = $signed({1'b0, res_reg[NS-1][OP_W-2:0]});
        dir_a  = OP_W'(da_reg[NS-1]);
        dir_b  = OP_W'(db_reg[NS-1]);
        if (rp_reg[NS-1])
        begin
            roll_a  = dir_a;
            roll_b  = dir_b;
            pitch_a = num_sc;
            pitch_b = root_b;
        end
        else
        begin
            roll_a  = num_sc;
            roll_b  = root_b;
            pitch_a = dir_a;
            pitch_b = dir_b;
        end
    end

    assign out_valid = vq_reg[NS-1];

endmodule

// ----- hw/rtl/atrp_cordic.sv -----
`timescale 1ns / 1ps

module atrp_cordic
#(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [atrp_pkg::OP_W-1:0]  in_a,
    input  logic signed [atrp_pkg::OP_W-1:0]  in_b,
    output logic                              out_valid,
    output logic signed [atrp_pkg::OUT_W-1:0] angle
);

    localparam int OP_W  = atrp_pkg::OP_W;
    localparam int NGRP  = OP_W / 8;
    localparam int CW    = atrp_pkg::CW;
    localparam int Z_W   = atrp_pkg::Z_W;
    localparam int PHI_W = atrp_pkg::PHI_W;
    localparam int OUT_W = atrp_pkg::OUT_W;
    localparam int NS    = atrp_pkg::CORDIC_STEPS + 1;
    localparam int SH    = 32 - ANGLE_FRAC_BITS;
    localparam logic [63:0] HALF = 64'(1) << (SH - 1);
    localparam logic signed [PHI_W-1:0] PHI90  = PHI_W'(90) << 32;
    localparam logic signed [PHI_W-1:0] PHI180 = PHI_W'(180) << 32;

    // magnitude stage
    logic             v0_reg;
    logic [OP_W-1:0]  xa0_reg;
    logic [OP_W-1:0]  ya0_reg;
    logic             sa0_reg;
    logic             sb0_reg;

    // coarse leading one search
    logic             v1_reg;
    logic [OP_W-1:0]  xa1_reg;
    logic [OP_W-1:0]  ya1_reg;
    logic             sa1_reg;
    logic             sb1_reg;
    logic [2:0]       grp1_reg;
    logic [7:0]       byte1_reg;
    logic [OP_W-1:0]  orv;
    logic [2:0]       grp;

    // fine search, shift count
    logic             v2_reg;
    logic [OP_W-1:0]  xa2_reg;
    logic [OP_W-1:0]  ya2_reg;
    logic             sa2_reg;
    logic             sb2_reg;
    logic [5:0]       k2_reg;
    logic [2:0]       pos;
    logic [6:0]       blen;
    logic [5:0]       k_calc;

    // rotation stages
    logic                  vc_reg [NS];
    logic signed [CW-1:0]  x_reg  [NS];
    logic signed [CW-1:0]  y_reg  [NS];
    logic signed [Z_W-1:0] z_reg  [NS];
    logic                  sa_reg [NS];
    logic                  sb_reg [NS];

    // quadrant and rounding
    logic                    vp_reg;
    logic signed [PHI_W-1:0] phi_reg;
    logic signed [PHI_W-1:0] phi;
    logic                    vo_reg;
    logic signed [OUT_W-1:0] angle_reg;
    logic [PHI_W-1:0]        mag;
    logic [63:0]             rsum;
    logic [OUT_W-1:0]        q;

    always_comb
    begin
        orv = xa0_reg | ya0_reg;
        grp = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (|orv[8*g +: 8])
                grp = 3'(g);
        end
    end

    always_comb
    begin
        pos = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (byte1_reg[b])
                pos = 3'(b);
        end
        blen   = {1'b0, grp1_reg, 3'b000} + 7'(pos) + 7'd1;
        k_calc = (byte1_reg == '0 || blen >= 7'(atrp_pkg::NORM_LEN))
                 ? 6'd0 : 6'(7'(atrp_pkg::NORM_LEN) - blen);
    end

    // front stages of the normalizer
    always_ff @(posedge clk)
    begin
        xa0_reg   <= in_b[OP_W-1] ? unsigned'(-in_b) : unsigned'(in_b);
        ya0_reg   <= in_a[OP_W-1] ? unsigned'(-in_a) : unsigned'(in_a);
        sa0_reg   <= in_a[OP_W-1];
        sb0_reg   <= in_b[OP_W-1];
        xa1_reg   <= xa0_reg;
        ya1_reg   <= ya0_reg;
        sa1_reg   <= sa0_reg;
        sb1_reg   <= sb0_reg;
        grp1_reg  <= grp;
        byte1_reg <= orv[8*grp +: 8];
        xa2_reg   <= xa1_reg;
        ya2_reg   <= ya1_reg;
        sa2_reg   <= sa1_reg;
        sb2_reg   <= sb1_reg;
        k2_reg    <= k_calc;
        x_reg[0]  <= $signed({2'b00, xa2_reg << k2_reg});
        y_reg[0]  <= $signed({2'b00, ya2_reg << k2_reg});
        z_reg[0]  <= '0;
        sa_reg[0] <= sa2_reg;
        sb_reg[0] <= sb2_reg;
    end

    // one micro-rotation per stage, idle once y reaches zero
    for (genvar i = 0; i < atrp_pkg::CORDIC_STEPS; i++)
    begin : g_rot
        localparam logic signed [Z_W-1:0] ANG = $signed(Z_W'(atrp_pkg::cordic_angle(i)));
        logic signed [CW-1:0]  dx;
        logic signed [CW-1:0]  dy;
        logic signed [CW-1:0]  x_n;
        logic signed [CW-1:0]  y_n;
        logic signed [Z_W-1:0] z_n;

        always_comb
        begin
            dx  = x_reg[i] >>> i;
            dy  = y_reg[i] >>> i;
            x_n = x_reg[i];
            y_n = y_reg[i];
            z_n = z_reg[i];
            if (y_reg[i] != '0)
            begin
                if (!y_reg[i][CW-1])
                begin
                    x_n = x_reg[i] + dy;
                    y_n = y_reg[i] - dx;
                    z_n = z_reg[i] + ANG;
                end
                else
                begin
                    x_n = x_reg[i] - dy;
                    y_n = y_reg[i] + dx;
                    z_n = z_reg[i] - ANG;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]  <= x_n;
            y_reg[i+1]  <= y_n;
            z_reg[i+1]  <= z_n;
            sa_reg[i+1] <= sa_reg[i];
            sb_reg[i+1] <= sb_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vc_reg[i+1] <= 1'b0;
            else
                vc_reg[i+1] <= vc_reg[i];
        end
    end

    // clamp to the first quadrant, then unfold
    always_comb
    begin
        if (z_reg[NS-1][Z_W-1])
            phi = '0;
        else if (PHI_W'(z_reg[NS-1]) > PHI90)
            phi = PHI90;
        else
            phi = PHI_W'(z_reg[NS-1]);
        if (sb_reg[NS-1])
            phi = PHI180 - phi;
        if (sa_reg[NS-1])
            phi = -phi;
    end

    // round half away from zero, keep the low output bits
    always_comb
    begin
        mag  = phi_reg[PHI_W-1] ? unsigned'(-phi_reg) : unsigned'(phi_reg);
        rsum = 64'(mag) + HALF;
        q    = rsum[SH +: OUT_W];
    end

    always_ff @(posedge clk)
    begin
        phi_reg   <= phi;
        angle_reg <= phi_reg[PHI_W-1] ? $signed(-q) : $signed(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vc_reg[0] <= 1'b0;
            vp_reg    <= 1'b0;
            vo_reg    <= 1'b0;
        end
        else
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            vc_reg[0] <= v2_reg;
            vp_reg    <= vc_reg[NS-1];
            vo_reg    <= vp_reg;
        end
    end

    assign out_valid = vo_reg;
    assign angle     = angle_reg;

endmodule

// ----- hw/rtl/accel_tilt_roll_pitch.sv -----
`timescale 1ns / 1ps

// channel   signals                                   handshake
// -------   ---------------------------------------   -------------------------
// sample    start, busy, accel_x, accel_y, accel_z     taken when start && !busy
// config    cfg_valid, cfg_ready, cfg_data             taken when valid && ready
// result    done, roll_deg, pitch_deg                  one-cycle strobe on done
//
// one sample per cycle is accepted while busy is low; each result passes the
// 31-stage square root followed by the 32-stage cordic pipelines (roll and
// pitch run side by side) after the sample leaves the input queue.
// rst_n is asynchronous and active low; it clears all valid bits and sets
// the pitch-limit mode to 1. the receiver cannot stall; busy rises only if the
// input queue is full.

module accel_tilt_roll_pitch
#(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = atrp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [atrp_pkg::IN_W-1:0]  accel_x,
    input  logic signed [atrp_pkg::IN_W-1:0]  accel_y,
    input  logic signed [atrp_pkg::IN_W-1:0]  accel_z,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    output logic                              done,
    output logic signed [atrp_pkg::OUT_W-1:0] roll_deg,
    output logic signed [atrp_pkg::OUT_W-1:0] pitch_deg
);

    localparam int LAT = atrp_pkg::ROOT_STEPS + 3 + atrp_pkg::CORDIC_STEPS + 6;

    atrp_pkg::atrp_qstat_t            qstat;
    atrp_pkg::atrp_item_t             push_item;
    atrp_pkg::atrp_item_t             head;
    logic                             push;
    logic                             pop;
    logic                             root_valid;
    logic signed [atrp_pkg::OP_W-1:0] roll_a;
    logic signed [atrp_pkg::OP_W-1:0] roll_b;
    logic signed [atrp_pkg::OP_W-1:0] pitch_a;
    logic signed [atrp_pkg::OP_W-1:0] pitch_b;
    logic                             roll_valid;
    logic                             pitch_valid;

    // classify and enqueue
    atrp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .item      (push_item)
    );

    atrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (qstat)
    );

    // back end drains a word every cycle while the queue is not empty
    assign pop  = !qstat.empty;
    assign busy = qstat.full;

    atrp_root u_root
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .in_item   (head),
        .out_valid (root_valid),
        .roll_a    (roll_a),
        .roll_b    (roll_b),
        .pitch_a   (pitch_a),
        .pitch_b   (pitch_b)
    );

    atrp_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_a      (roll_a),
        .in_b      (roll_b),
        .out_valid (roll_valid),
        .angle     (roll_deg)
    );

    atrp_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_a      (pitch_a),
        .in_b      (pitch_b),
        .out_valid (pitch_valid),
        .angle     (pitch_deg)
    );

    assign done = roll_valid;

    // fixed latency from queue to result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ##LAT done)
        else $error("result strobe missing after fixed latency");

    // both angle pipelines stay in step
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        roll_valid == pitch_valid)
        else $error("roll and pitch pipelines out of step");

    // no word pushed while queue full
    a_queue: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !qstat.empty && !push)
        else $error("queue full state inconsistent");

endmodule
